// ===== src/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// types and constants shared by the fixed-point alu
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;

  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned DIV_BITS      = WORD_BITS + FRACTION_BITS;
  localparam int unsigned DIV_STEPS     = 4;
  localparam int unsigned DIV_STAGES    = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned LAT           = DIV_STAGES + 2;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_GT = 4'd4, CMD_LT = 4'd5, CMD_GE = 4'd6, CMD_LE = 4'd7,
    CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
    CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_FROM_INT = 4'd14, CMD_TO_INT = 4'd15
  } cmd_e;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               overflow;
    logic               divide_by_zero;
  } fpa_out_t;

  // result computed early plus the divider operands
  typedef struct packed {
    logic               is_div;
    logic               neg_q;
    logic [DIV_BITS-1:0] rem;
    logic [DIV_BITS-1:0] quo;
    logic [WORD_BITS-1:0] den;
    fpa_out_t           res;
  } fpa_work_t;

endpackage
`default_nettype wire

// ===== src/fpa_front.sv =====
// ----------------------------------------------------------------------------
// fpa_front
// decode, add/sub/compare, min/max, inc/dec, int conversion, multiply and divider setup; one register stage
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_front import fpa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      en_i,
  input  wire fpa_in_t   in_i,
  output fpa_work_t      work_o
);
  localparam int unsigned PW = 2 * WORD_BITS;

  logic signed [WORD_BITS:0]   a, b;
  logic signed [WORD_BITS+1:0] sum, dif, s1;
  logic signed [PW-1:0]        prod, sh;
  logic signed [WORD_BITS+FRACTION_BITS:0] fi;
  logic signed [WORD_BITS:0]   ti;
  logic [WORD_BITS-1:0]        mag_a, mag_b;
  logic                        lt, eq;
  logic signed [PW-1:0]        ex;
  fpa_work_t                   w;

  always_comb begin
    a    = (WORD_BITS+1)'($signed(in_i.operand_a[WORD_BITS-1:0]));
    b    = (WORD_BITS+1)'($signed(in_i.operand_b[WORD_BITS-1:0]));
    sum  = a + b;
    dif  = a - b;
    lt   = a < b;
    eq   = a == b;
    prod = PW'(a) * PW'(b);
    sh   = prod >>> FRACTION_BITS;
    fi   = (WORD_BITS+FRACTION_BITS+1)'(a) <<< FRACTION_BITS;
    ti   = a >>> FRACTION_BITS;
    s1   = '0;
    mag_a = a[WORD_BITS] ? WORD_BITS'(-a) : a[WORD_BITS-1:0];
    mag_b = b[WORD_BITS] ? WORD_BITS'(-b) : b[WORD_BITS-1:0];
    ex   = '0;
    w    = '0;
    case (cmd_e'(in_i.command))
      CMD_ADD:      ex = PW'(sum);
      CMD_SUB:      ex = PW'(dif);
      CMD_MUL:      ex = sh;
      CMD_GT:       w.res.compare_true = !lt && !eq;
      CMD_LT:       w.res.compare_true = lt;
      CMD_GE:       w.res.compare_true = !lt;
      CMD_LE:       w.res.compare_true = lt || eq;
      CMD_EQ:       w.res.compare_true = eq;
      CMD_NE:       w.res.compare_true = !eq;
      CMD_MIN:      ex = PW'(lt ? a : b);
      CMD_MAX:      ex = PW'((!lt && !eq) ? a : b);
      CMD_INC:      begin s1 = a + 1; ex = PW'(s1); end
      CMD_DEC:      begin s1 = a - 1; ex = PW'(s1); end
      CMD_FROM_INT: ex = PW'(fi);
      CMD_TO_INT:   ex = PW'(ti);
      default:      ex = '0;
    endcase
    w.res.result_value = 32'($signed(ex[WORD_BITS-1:0]));
    w.res.overflow = ex != PW'($signed(ex[WORD_BITS-1:0]));
    if (cmd_e'(in_i.command) == CMD_DIV) begin
      w.is_div = 1'b1;
      w.res.divide_by_zero = (b == '0);
      w.res.overflow = 1'b0;
      w.res.result_value = '0;
      w.neg_q = a[WORD_BITS] ^ b[WORD_BITS];
      w.quo = DIV_BITS'(mag_a) << FRACTION_BITS;
      w.den = mag_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_o <= w;
    end
  end
endmodule
`default_nettype wire

// ===== src/fpa_div_stage.sv =====
// ----------------------------------------------------------------------------
// fpa_div_stage
// four restoring division steps followed by a register
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_div_stage import fpa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      en_i,
  input  wire fpa_work_t work_i,
  output fpa_work_t      work_o
);
  fpa_work_t w;
  logic [DIV_BITS:0] t;

  always_comb begin
    w = work_i;
    t = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {w.rem, w.quo[DIV_BITS-1]};
      w.quo = w.quo << 1;
      if (t >= (DIV_BITS+1)'(w.den)) begin
        t = t - (DIV_BITS+1)'(w.den);
        w.quo[0] = 1'b1;
      end
      w.rem = t[DIV_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_o <= w;
    end
  end
endmodule
`default_nettype wire

// ===== src/fpa_back.sv =====
// ----------------------------------------------------------------------------
// fpa_back
// divide sign fix, wrap and overflow; result register
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_back import fpa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      en_i,
  input  wire fpa_work_t work_i,
  output fpa_out_t       res_o
);
  localparam int unsigned SH = DIV_STAGES * DIV_STEPS - DIV_BITS;
  fpa_out_t r;
  logic [DIV_BITS-1:0] q;
  logic signed [DIV_BITS:0] sq;

  always_comb begin
    r  = work_i.res;
    q  = work_i.quo << SH;
    sq = work_i.neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (work_i.is_div && !work_i.res.divide_by_zero) begin
      r.result_value = 32'($signed(sq[WORD_BITS-1:0]));
      r.overflow = sq != (DIV_BITS+1)'($signed(sq[WORD_BITS-1:0]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= r;
    end
  end
endmodule
`default_nettype wire

// ===== src/fixed_point_alu_top.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// pipelined q24.8 fixed-point alu
// ----------------------------------------------------------------------------
// One beat per cycle enters while the pipe advances; the divider retires four
// quotient bits per stage over ten stages.
// The whole pipe advances when the output register is empty or being taken.
`default_nettype none
module fixed_point_alu_top import fpa_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire fpa_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output fpa_out_t      out_data_o
);
  logic [LAT-1:0] vld_q, vld_d;
  logic           adv;
  fpa_work_t      st [DIV_STAGES+1];

  assign adv         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[LAT-1];
  assign vld_d       = {vld_q[LAT-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  fpa_front u_front (.clk_i, .en_i(adv), .in_i(in_data_i), .work_o(st[0]));

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    fpa_div_stage u_div (.clk_i, .en_i(adv), .work_i(st[g]), .work_o(st[g+1]));
  end

  fpa_back u_back (.clk_i, .en_i(adv), .work_i(st[DIV_STAGES]), .res_o(out_data_o));
endmodule
`default_nettype wire

// ===== src/fpa_checker.sv =====
// ----------------------------------------------------------------------------
// fpa_checker
// port-level checks on the fixed-point alu
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_checker import fpa_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire fpa_out_t out_data_o
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o)) else $error("stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i)) else $error("ready");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.compare_true, out_data_o.overflow,
    out_data_o.divide_by_zero}) <= 1) else $error("flags");
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.compare_true || out_data_o.divide_by_zero)
    |-> out_data_o.result_value == '0) else $error("zero");
endmodule

bind fixed_point_alu_top fpa_checker u_chk (.clk_i, .rst_ni, .in_ready_o,
  .out_valid_o, .out_ready_i, .out_data_o);
`default_nettype wire

// ===== test/fixed_point_alu_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_alu_top_tb
// self-checking bench for the pipelined q24.8 fixed-point alu
// ----------------------------------------------------------------------------
// Directed corner operands for every command, then random beats biased toward
// edge values. Results are predicted in order and compared field by field,
// with random idling on both sides and one long output hold-off.
`default_nettype none
module fixed_point_alu_top_tb;
  import fpa_pkg::*;

  localparam int unsigned N_RANDOM  = 750;
  localparam int unsigned MAX_CYCLE = 200000;

  class alu_scoreboard;
    fpa_out_t pending_q[$];
    int unsigned mismatches;

    function automatic fpa_out_t compute(fpa_in_t beat);
      fpa_out_t r;
      logic signed [63:0] a, b, exact, prod;
      logic arith;
      a = 64'(beat.operand_a);
      b = 64'(beat.operand_b);
      exact = '0;
      arith = 1'b1;
      r = '0;
      case (cmd_e'(beat.command))
        CMD_ADD: exact = a + b;
        CMD_SUB: exact = a - b;
        CMD_MUL: begin
          prod = a * b;
          exact = prod >>> FRACTION_BITS;
        end
        CMD_DIV: begin
          if (b == 0) begin
            r.divide_by_zero = 1'b1;
          end else begin
            exact = (a <<< FRACTION_BITS) / b;
          end
        end
        CMD_GT: begin r.compare_true = a > b; arith = 1'b0; end
        CMD_LT: begin r.compare_true = a < b; arith = 1'b0; end
        CMD_GE: begin r.compare_true = a >= b; arith = 1'b0; end
        CMD_LE: begin r.compare_true = a <= b; arith = 1'b0; end
        CMD_EQ: begin r.compare_true = a == b; arith = 1'b0; end
        CMD_NE: begin r.compare_true = a != b; arith = 1'b0; end
        CMD_MIN: exact = (a < b) ? a : b;
        CMD_MAX: exact = (a > b) ? a : b;
        CMD_INC: exact = a + 1;
        CMD_DEC: exact = a - 1;
        CMD_FROM_INT: exact = a <<< FRACTION_BITS;
        default: exact = a >>> FRACTION_BITS;
      endcase
      if (!arith) exact = '0;
      r.result_value = exact[31:0];
      r.overflow = (exact != 64'(signed'(exact[31:0])));
      return r;
    endfunction

    function void note_input(fpa_in_t beat);
      pending_q.push_back(compute(beat));
    endfunction

    function void check_result(fpa_out_t got);
      fpa_out_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.result_value !== want.result_value || got.compare_true !== want.compare_true ||
          got.overflow !== want.overflow || got.divide_by_zero !== want.divide_by_zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp val=%h cmp=%b ovf=%b dbz=%b, got val=%h cmp=%b ovf=%b dbz=%b",
                   want.result_value, want.compare_true, want.overflow, want.divide_by_zero,
                   got.result_value, got.compare_true, got.overflow, got.divide_by_zero);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  fpa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  fpa_out_t out_data;

  alu_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt = 0;
  bit quiet_phase = 1'b0;
  bit hold_off = 1'b0;

  always #6 clk = ~clk;

  fixed_point_alu_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: random stalls, one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= !hold_off && (quiet_phase || $urandom_range(99) >= 6);
    end
  end

  initial begin
    wait (sent_cnt == 300);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(512)) - 256);
      3: return '0;
      4: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
    fpa_in_t beat;
    beat.command = cmd;
    beat.operand_a = a;
    beat.operand_b = b;
    while (!quiet_phase && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(beat);
    sent_cnt++;
  endtask

  initial begin
    logic [31:0] corner[5];
    int unsigned wait_cnt;
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_0100};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners, every command
    for (int c = 0; c < 16; c++)
      send_beat(c[3:0], corner[c % 5], corner[(c + 2) % 5]);
    send_beat(CMD_DIV, 32'h0000_0300, 32'h0);
    send_beat(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(CMD_MUL, 32'hffff_ffff, 32'h0000_0001);
    send_beat(CMD_DIV, 32'hffff_fd00, 32'h0000_0200);
    send_beat(CMD_INC, 32'h7fff_ffff, 32'hffff_ffff);
    send_beat(CMD_DEC, 32'h8000_0000, 32'h0);
    send_beat(CMD_EQ, 32'h1234_5678, 32'h1234_5678);
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet_phase = (i >= 450 && i < 600);
      send_beat(4'($urandom_range(15)), pick_operand(), pick_operand());
    end
    quiet_phase = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (wait_cnt < 2 * LAT) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
